/* hw/rtl/owsfc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owsfc_pkg
// shared types, constants and codes of the one-wire sensor frame checker
// ----------------------------------------------------------------------------
package owsfc_pkg;

  localparam int ROM_BYTES_DEF        = 8;
  localparam int SCRATCHPAD_BYTES_DEF = 9;

  localparam int CNT_W = 4;
  localparam int LEN_W = CNT_W + 1;

  localparam logic [7:0] CFG_MASK    = 8'h9f;
  localparam logic [7:0] CFG_PATTERN = 8'h1f;
  localparam logic [CNT_W-1:0] CFG_POS     = CNT_W'(4);
  localparam logic [CNT_W-1:0] TEMP_LO_POS = CNT_W'(0);
  localparam logic [CNT_W-1:0] TEMP_HI_POS = CNT_W'(1);

  localparam logic [7:0] CRC_GEN_RESET = 8'h8c;
  localparam logic       MODE_RESET    = 1'b1;

  localparam logic MODE_ROM        = 1'b0;
  localparam logic MODE_SCRATCHPAD = 1'b1;

  localparam logic REG_FRAME_MODE    = 1'b0;
  localparam logic REG_CRC_GENERATOR = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_CFG_BAD = 2'd1;
  localparam logic [1:0] STATUS_CRC_BAD = 2'd2;

  typedef struct packed {
    logic       frame_mode;
    logic [7:0] crc_generator;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic [1:0]         status;
    logic signed [15:0] temperature;
    logic [7:0]         computed_crc;
  } res_t;

endpackage

/* hw/rtl/owsfc_crc8.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owsfc_crc8
// bytewise reflected crc-8 update with a programmable feedback polynomial
// ----------------------------------------------------------------------------
module owsfc_crc8 (
  input  logic [7:0] crc_in,
  input  logic [7:0] data,
  input  logic [7:0] generator,
  output logic [7:0] crc_out
);

  always_comb begin
    logic [7:0] c;
    c = crc_in ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = {1'b0, c[7:1]} ^ generator;
      end else begin
        c = {1'b0, c[7:1]};
      end
    end
    crc_out = c;
  end

endmodule

/* hw/rtl/owsfc_frame.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owsfc_frame
// frame tracking, crc accumulation and end-of-frame check for one item a cycle while advance is high
// ----------------------------------------------------------------------------
module owsfc_frame #(
  parameter int ROM_BYTES        = owsfc_pkg::ROM_BYTES_DEF,
  parameter int SCRATCHPAD_BYTES = owsfc_pkg::SCRATCHPAD_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [7:0]        data_byte,
  input  logic              frame_start,
  input  owsfc_pkg::cfg_t   cfg,
  output owsfc_pkg::res_t   res
);

  localparam logic [owsfc_pkg::LEN_W-1:0] ROM_LEN = owsfc_pkg::LEN_W'(ROM_BYTES);
  localparam logic [owsfc_pkg::LEN_W-1:0] SCR_LEN = owsfc_pkg::LEN_W'(SCRATCHPAD_BYTES);

  logic [7:0]                  crc_register;
  logic [owsfc_pkg::CNT_W-1:0] byte_count;
  logic [7:0]                  temp_low_byte;
  logic [7:0]                  temp_high_byte;
  logic                        config_byte_ok;
  logic                        in_frame;

  logic [7:0]                  crc_base;
  logic [owsfc_pkg::CNT_W-1:0] pos;
  logic [7:0]                  tlo_base;
  logic [7:0]                  thi_base;
  logic                        cfg_ok_base;
  logic [owsfc_pkg::LEN_W-1:0] len;
  logic                        take;
  logic                        is_last;
  logic [7:0]                  crc_upd;

  always_comb begin
    take        = advance && (frame_start || in_frame);
    pos         = frame_start ? '0 : byte_count;
    crc_base    = frame_start ? 8'h00 : crc_register;
    tlo_base    = frame_start ? 8'h00 : temp_low_byte;
    thi_base    = frame_start ? 8'h00 : temp_high_byte;
    cfg_ok_base = frame_start ? 1'b0 : config_byte_ok;
    len         = (cfg.frame_mode == owsfc_pkg::MODE_SCRATCHPAD) ? SCR_LEN : ROM_LEN;
    is_last     = ({1'b0, pos} + owsfc_pkg::LEN_W'(1)) >= len;
  end

  owsfc_crc8 u_crc8 (
    .crc_in    (crc_base),
    .data      (data_byte),
    .generator (cfg.crc_generator),
    .crc_out   (crc_upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_register   <= 8'h00;
      byte_count     <= '0;
      temp_low_byte  <= 8'h00;
      temp_high_byte <= 8'h00;
      config_byte_ok <= 1'b0;
      in_frame       <= 1'b0;
    end else if (take) begin
      if (is_last) begin
        in_frame   <= 1'b0;
        byte_count <= '0;
      end else begin
        in_frame       <= 1'b1;
        byte_count     <= pos + owsfc_pkg::CNT_W'(1);
        crc_register   <= crc_upd;
        temp_low_byte  <= tlo_base;
        temp_high_byte <= thi_base;
        config_byte_ok <= cfg_ok_base;
        if (cfg.frame_mode == owsfc_pkg::MODE_SCRATCHPAD) begin
          if (pos == owsfc_pkg::TEMP_LO_POS) begin
            temp_low_byte <= data_byte;
          end else if (pos == owsfc_pkg::TEMP_HI_POS) begin
            temp_high_byte <= data_byte;
          end else if (pos == owsfc_pkg::CFG_POS) begin
            config_byte_ok <= (data_byte & owsfc_pkg::CFG_MASK) == owsfc_pkg::CFG_PATTERN;
          end
        end
      end
    end
  end

  always_comb begin
    res.valid        = take && is_last;
    res.computed_crc = crc_base;
    res.status       = owsfc_pkg::STATUS_OK;
    res.temperature  = 16'sd0;
    if (cfg.frame_mode == owsfc_pkg::MODE_SCRATCHPAD) begin
      res.temperature = $signed({thi_base, tlo_base});
      if (!cfg_ok_base) begin
        res.status = owsfc_pkg::STATUS_CFG_BAD;
      end else if (data_byte != crc_base) begin
        res.status = owsfc_pkg::STATUS_CRC_BAD;
      end
    end else if (data_byte != crc_base) begin
      res.status = owsfc_pkg::STATUS_CRC_BAD;
    end
  end

endmodule

/* hw/rtl/owsfc_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owsfc_out_reg
// result register driving the master-side stream
// ----------------------------------------------------------------------------
module owsfc_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  owsfc_pkg::res_t  res,
  output logic             busy,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [31:0]      m_tdata
);

  logic [1:0]         status_q;
  logic signed [15:0] temp_q;
  logic [7:0]         crc_q;

  assign busy     = m_tvalid && !m_tready;
  assign m_tdata  = {6'b0, crc_q, temp_q, status_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load && res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.valid) begin
      status_q <= res.status;
      temp_q   <= res.temperature;
      crc_q    <= res.computed_crc;
    end
  end

endmodule

/* hw/rtl/onewire_sensor_frame_checker_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onewire_sensor_frame_checker_core
// checks one-wire sensor frames: crc-8, configuration byte and temperature
// path: a closing item passes the input register, then the result register, to the master side
// throughput: one item per cycle while the master side does not stall; the bytewise crc update is combinational
// reset: synchronous; clears frame state and both stream sides, config to defaults
// ----------------------------------------------------------------------------
module onewire_sensor_frame_checker_core #(
  parameter int ROM_BYTES        = owsfc_pkg::ROM_BYTES_DEF,
  parameter int SCRATCHPAD_BYTES = owsfc_pkg::SCRATCHPAD_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tuser,   // frame_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // status[1:0], temperature[17:2], computed_crc[25:18]
);

  owsfc_pkg::cfg_t cfg;
  owsfc_pkg::res_t res;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_start;
  logic       advance;
  logic       out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_mode    <= owsfc_pkg::MODE_RESET;
      cfg.crc_generator <= owsfc_pkg::CRC_GEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        owsfc_pkg::REG_FRAME_MODE:    cfg.frame_mode    <= cfg_data[0];
        owsfc_pkg::REG_CRC_GENERATOR: cfg.crc_generator <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance  = in_valid && !out_busy;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte  <= s_tdata;
      in_start <= s_tuser;
    end
  end

  owsfc_frame #(
    .ROM_BYTES        (ROM_BYTES),
    .SCRATCHPAD_BYTES (SCRATCHPAD_BYTES)
  ) u_frame (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .data_byte   (in_byte),
    .frame_start (in_start),
    .cfg         (cfg),
    .res         (res)
  );

  owsfc_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .res      (res),
    .busy     (out_busy),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
